// ----- design/tcw_pkg.sv -----
package tcw_pkg;

  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int INDEX_W = 11;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CFG_IW  = 1;

  localparam logic [CFG_IW-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IW-1:0] REG_ALERT_ATTR   = 1'b1;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'd7;
  localparam logic [ATTR_W-1:0] ALERT_ATTR_RST   = 8'd4;

  localparam logic [CHAR_W-1:0] CH_ESC    = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_J      = 8'h4A;
  localparam logic [CHAR_W-1:0] CH_H      = 8'h48;
  localparam logic [CHAR_W-1:0] CH_M      = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_THREE  = 8'h33;
  localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;
  localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;

  typedef enum logic [2:0] {
    CLS_ESC, CLS_CR, CLS_LF, CLS_TAB, CLS_BS, CLS_PRINT, CLS_CTRL
  } cls_t;

  typedef struct packed {
    logic               action;
    logic [CHAR_W-1:0]  char_code;
    logic [INDEX_W-1:0] cell_index;
    cls_t               cls;
    logic               is_final;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic [ROW_W-1:0]  shown_row;
    logic [COL_W-1:0]  shown_col;
    logic [ATTR_W-1:0] shown_attr;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_TAB, S_BLANK, S_RDIV, S_RMEM, S_DONE
  } bstate_t;

  typedef enum logic [1:0] {
    ESC_IDLE, ESC_SEEN, ESC_SEQ
  } esc_phase_t;

  typedef enum logic [1:0] {
    SEL_NONE, SEL_DEF, SEL_ALERT
  } sel_t;

endpackage

// ----- design/tcw_front.sv -----
module tcw_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        action,
  input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] cell_index,
  input  logic                        hold,
  output logic                        full,
  input  logic                        take,
  output logic                        avail,
  output tcw_pkg::item_t              head
);

  tcw_pkg::item_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  tcw_pkg::item_t cls_item;
  logic           do_push, do_pop;

  always_comb begin
    cls_item.action     = action;
    cls_item.char_code  = char_code;
    cls_item.cell_index = cell_index;
    cls_item.is_final   = (char_code >= tcw_pkg::CH_AT) && (char_code <= tcw_pkg::CH_TILDE);
    if (char_code == tcw_pkg::CH_ESC) cls_item.cls = tcw_pkg::CLS_ESC;
    else if (char_code == tcw_pkg::CH_CR) cls_item.cls = tcw_pkg::CLS_CR;
    else if (char_code == tcw_pkg::CH_LF) cls_item.cls = tcw_pkg::CLS_LF;
    else if (char_code == tcw_pkg::CH_TAB) cls_item.cls = tcw_pkg::CLS_TAB;
    else if (char_code == tcw_pkg::CH_BS || char_code == tcw_pkg::CH_DEL)
      cls_item.cls = tcw_pkg::CLS_BS;
    else if (char_code >= tcw_pkg::CH_SPACE) cls_item.cls = tcw_pkg::CLS_PRINT;
    else cls_item.cls = tcw_pkg::CLS_CTRL;
  end

  assign full    = (cnt_r == 2'd2) || hold;
  assign avail   = (cnt_r != 2'd0);
  assign head    = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= cls_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- design/tcw_outq.sv -----
module tcw_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             put,
  input  tcw_pkg::result_t din,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output tcw_pkg::result_t dout
);

  tcw_pkg::result_t q_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_put, do_pop;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign dout   = q_r[rp_r];
  assign do_put = put && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_put) q_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_put) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_put} - {1'b0, do_pop};
    end
  end

endmodule

// ----- design/tcw_back.sv -----
module tcw_back #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int TAB_STOP     = 8,
  parameter int ESCAPE_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [tcw_pkg::ATTR_W-1:0] default_attr,
  input  logic [tcw_pkg::ATTR_W-1:0] alert_attr,
  input  logic                       avail,
  input  tcw_pkg::item_t             item,
  output logic                       take,
  output logic                       init_busy,
  input  logic                       res_full,
  output logic                       res_put,
  output tcw_pkg::result_t           res
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int TW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int LW    = $clog2(ESCAPE_DEPTH);
  localparam logic [RW:0]   ROWS_P   = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [TW-1:0] LAST_TAB = TW'(TAB_STOP - 1);
  localparam logic [TW-1:0] LAST_MOD = TW'((COLUMNS - 1) % TAB_STOP);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [LW-1:0] LEN_MAX  = LW'(ESCAPE_DEPTH - 1);
  localparam logic [tcw_pkg::INDEX_W:0] CELLS_W = (tcw_pkg::INDEX_W+1)'(CELLS);
  localparam logic [tcw_pkg::INDEX_W-1:0] COLS_I = tcw_pkg::INDEX_W'(COLUMNS);

  logic [15:0] mem [CELLS];
  logic [15:0] rdata_r;
  logic        we;
  logic [AW-1:0] wa, ra;
  logic [15:0]   wd;

  tcw_pkg::bstate_t    state_r, state_nxt;
  tcw_pkg::esc_phase_t phase_r, phase_nxt;
  tcw_pkg::sel_t       sel_r, sel_nxt;
  logic [RW-1:0] row_r, row_nxt, top_r, top_nxt, brow_r, brow_nxt, rrow_r, rrow_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [TW-1:0] mod_r, mod_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          prev3_r, prev3_nxt;
  logic [tcw_pkg::ATTR_W-1:0] attr_r, attr_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [tcw_pkg::INDEX_W-1:0] idx_r, idx_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  rc_r, rc_nxt;
  logic [tcw_pkg::ATTR_W-1:0]  ra_r, ra_nxt;
  logic [tcw_pkg::CHAR_W-1:0]  ch;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [RW-1:0] t,
                                               input logic [CW-1:0] c);
    logic [RW:0] p;
    begin
      p = {1'b0, r} + {1'b0, t};
      if (p >= ROWS_P) p = p - ROWS_P;
      cell_addr = AW'(int'(p) * COLUMNS + int'(c));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[ra];
  end

  assign ch = item.char_code;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    sel_nxt   = sel_r;
    row_nxt   = row_r;
    top_nxt   = top_r;
    brow_nxt  = brow_r;
    rrow_nxt  = rrow_r;
    col_nxt   = col_r;
    mod_nxt   = mod_r;
    len_nxt   = len_r;
    prev3_nxt = prev3_r;
    attr_nxt  = attr_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    rc_nxt    = rc_r;
    ra_nxt    = ra_r;
    we        = 1'b0;
    wa        = cell_addr(row_r, top_r, col_r);
    wd        = {attr_r, ch};
    ra        = cell_addr(rrow_r, top_r, idx_r[CW-1:0]);
    take      = 1'b0;
    res_put   = 1'b0;

    case (state_r)
      tcw_pkg::S_INIT, tcw_pkg::S_CLEAR: begin
        we      = 1'b1;
        wa      = cnt_r;
        wd      = {(state_r == tcw_pkg::S_INIT) ? tcw_pkg::DEFAULT_ATTR_RST : default_attr,
                   tcw_pkg::CH_SPACE};
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == LAST_CELL) begin
          state_nxt = (state_r == tcw_pkg::S_INIT) ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
        end
      end
      tcw_pkg::S_IDLE: begin
        if (avail) begin
          take      = 1'b1;
          state_nxt = tcw_pkg::S_DONE;
          rc_nxt    = '0;
          ra_nxt    = '0;
          if (item.action) begin
            if ({1'b0, item.cell_index} < CELLS_W) begin
              idx_nxt   = item.cell_index;
              rrow_nxt  = '0;
              state_nxt = tcw_pkg::S_RDIV;
            end
          end else if (phase_r == tcw_pkg::ESC_SEEN) begin
            phase_nxt = (ch == tcw_pkg::CH_LBRACK) ? tcw_pkg::ESC_SEQ : tcw_pkg::ESC_IDLE;
          end else if (phase_r == tcw_pkg::ESC_SEQ) begin
            if (len_r < LEN_MAX) begin
              len_nxt   = len_r + LW'(1);
              prev3_nxt = (ch == tcw_pkg::CH_THREE);
              if (ch == tcw_pkg::CH_ZERO) sel_nxt = tcw_pkg::SEL_DEF;
              if (ch == tcw_pkg::CH_ONE && prev3_r) sel_nxt = tcw_pkg::SEL_ALERT;
            end
            if (item.is_final) begin
              phase_nxt = tcw_pkg::ESC_IDLE;
              len_nxt   = '0;
              if (ch == tcw_pkg::CH_J) begin
                attr_nxt  = default_attr;
                row_nxt   = '0;
                col_nxt   = '0;
                mod_nxt   = '0;
                top_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = tcw_pkg::S_CLEAR;
              end else if (ch == tcw_pkg::CH_H) begin
                row_nxt = '0;
                col_nxt = '0;
                mod_nxt = '0;
              end else if (ch == tcw_pkg::CH_M) begin
                if (sel_r == tcw_pkg::SEL_DEF) attr_nxt = default_attr;
                else if (sel_r == tcw_pkg::SEL_ALERT) attr_nxt = alert_attr;
              end
            end
          end else begin
            case (item.cls)
              tcw_pkg::CLS_ESC: begin
                phase_nxt = tcw_pkg::ESC_SEEN;
                len_nxt   = '0;
                sel_nxt   = tcw_pkg::SEL_NONE;
                prev3_nxt = 1'b0;
              end
              tcw_pkg::CLS_CR: begin
                col_nxt = '0;
                mod_nxt = '0;
              end
              tcw_pkg::CLS_TAB: state_nxt = tcw_pkg::S_TAB;
              tcw_pkg::CLS_BS: begin
                if (col_r == '0) begin
                  if (row_r != '0) begin
                    row_nxt = row_r - RW'(1);
                    col_nxt = LAST_COL;
                    mod_nxt = LAST_MOD;
                    we      = 1'b1;
                    wa      = cell_addr(row_r - RW'(1), top_r, LAST_COL);
                    wd      = {attr_r, tcw_pkg::CH_SPACE};
                  end
                end else begin
                  col_nxt = col_r - CW'(1);
                  mod_nxt = (mod_r == '0) ? LAST_TAB : mod_r - TW'(1);
                  we      = 1'b1;
                  wa      = cell_addr(row_r, top_r, col_r - CW'(1));
                  wd      = {attr_r, tcw_pkg::CH_SPACE};
                end
              end
              tcw_pkg::CLS_LF, tcw_pkg::CLS_PRINT: begin
                we = (item.cls == tcw_pkg::CLS_PRINT);
                if (item.cls == tcw_pkg::CLS_PRINT && col_r != LAST_COL) begin
                  col_nxt = col_r + CW'(1);
                  mod_nxt = (mod_r == LAST_TAB) ? '0 : mod_r + TW'(1);
                end else begin
                  col_nxt = '0;
                  mod_nxt = '0;
                  if (row_r == LAST_ROW) begin
                    brow_nxt  = top_r;
                    top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
                    cnt_nxt   = '0;
                    state_nxt = tcw_pkg::S_BLANK;
                  end else begin
                    row_nxt = row_r + RW'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      tcw_pkg::S_TAB: begin
        we = 1'b1;
        wd = {attr_r, tcw_pkg::CH_SPACE};
        if (col_r != LAST_COL) begin
          col_nxt = col_r + CW'(1);
          mod_nxt = (mod_r == LAST_TAB) ? '0 : mod_r + TW'(1);
          if (mod_r == LAST_TAB) state_nxt = tcw_pkg::S_DONE;
        end else begin
          col_nxt   = '0;
          mod_nxt   = '0;
          state_nxt = tcw_pkg::S_DONE;
          if (row_r == LAST_ROW) begin
            brow_nxt  = top_r;
            top_nxt   = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
            cnt_nxt   = '0;
            state_nxt = tcw_pkg::S_BLANK;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end
      end
      tcw_pkg::S_BLANK: begin
        we      = 1'b1;
        wa      = cell_addr(brow_r, '0, cnt_r[CW-1:0]);
        wd      = {attr_r, tcw_pkg::CH_SPACE};
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r[CW-1:0] == LAST_COL) state_nxt = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_RDIV: begin
        if (idx_r >= COLS_I) begin
          idx_nxt  = idx_r - COLS_I;
          rrow_nxt = rrow_r + RW'(1);
        end else begin
          state_nxt = tcw_pkg::S_RMEM;
        end
      end
      tcw_pkg::S_RMEM: begin
        rc_nxt    = rdata_r[7:0];
        ra_nxt    = rdata_r[15:8];
        state_nxt = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_DONE: begin
        res_put = 1'b1;
        if (!res_full) state_nxt = tcw_pkg::S_IDLE;
      end
      default: state_nxt = tcw_pkg::S_IDLE;
    endcase
  end

  assign init_busy      = (state_r == tcw_pkg::S_INIT);
  assign res.read_char  = rc_r;
  assign res.read_attr  = ra_r;
  assign res.shown_row  = tcw_pkg::ROW_W'(row_r);
  assign res.shown_col  = tcw_pkg::COL_W'(col_r);
  assign res.shown_attr = attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::S_INIT;
      phase_r <= tcw_pkg::ESC_IDLE;
      sel_r   <= tcw_pkg::SEL_NONE;
      row_r   <= '0;
      top_r   <= '0;
      col_r   <= '0;
      mod_r   <= '0;
      len_r   <= '0;
      prev3_r <= 1'b0;
      attr_r  <= tcw_pkg::DEFAULT_ATTR_RST;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      sel_r   <= sel_nxt;
      row_r   <= row_nxt;
      top_r   <= top_nxt;
      col_r   <= col_nxt;
      mod_r   <= mod_nxt;
      len_r   <= len_nxt;
      prev3_r <= prev3_nxt;
      attr_r  <= attr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    brow_r <= brow_nxt;
    rrow_r <= rrow_nxt;
    idx_r  <= idx_nxt;
    rc_r   <= rc_nxt;
    ra_r   <= ra_nxt;
  end

endmodule

// ----- design/text_console_writer.sv -----
// Channel   Direction  Handshake                  Word
// in_       input      in_push / in_full          action, char_code, cell_index
// out_      output     out_empty / out_pop        read_char, read_attr, shown_*
// cfg_      input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A plain byte is taken in S_IDLE and its result handed over in S_DONE. A
// newline at the bottom row adds an S_BLANK pass over the COLUMNS cells of the
// row that scrolls in, a TAB an S_TAB pass up to the next tab stop, ESC [ J an
// S_CLEAR sweep of ROWS*COLUMNS cells, and a read an S_RDIV row search plus one
// registered memory read. After reset a clearing pass over ROWS*COLUMNS cells
// holds in_full high, while configuration writes are taken throughout. Two-deep
// queues on each side let the input and result sides stall alone.
module text_console_writer #(
  parameter int COLUMNS      = 80,
  parameter int ROWS         = 25,
  parameter int TAB_STOP     = 8,
  parameter int ESCAPE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_action,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char_code,
  input  logic [tcw_pkg::INDEX_W-1:0] in_cell_index,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [tcw_pkg::CHAR_W-1:0]  out_read_char,
  output logic [tcw_pkg::ATTR_W-1:0]  out_read_attr,
  output logic [tcw_pkg::ROW_W-1:0]   out_shown_row,
  output logic [tcw_pkg::COL_W-1:0]   out_shown_col,
  output logic [tcw_pkg::ATTR_W-1:0]  out_shown_attr,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tcw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]  cfg_data
);

  // Configuration registers; the port never stalls.
  logic [tcw_pkg::ATTR_W-1:0] default_attr_r, alert_attr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_attr_r <= tcw_pkg::DEFAULT_ATTR_RST;
      alert_attr_r   <= tcw_pkg::ALERT_ATTR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcw_pkg::REG_DEFAULT_ATTR: default_attr_r <= cfg_data;
        tcw_pkg::REG_ALERT_ATTR:   alert_attr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             avail, take, init_busy, res_full, res_put;
  tcw_pkg::item_t   head;
  tcw_pkg::result_t res, res_out;

  // Front end: classifies each byte and queues the word.
  tcw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .action     (in_action),
    .char_code  (in_char_code),
    .cell_index (in_cell_index),
    .hold       (init_busy),
    .full       (in_full),
    .take       (take),
    .avail      (avail),
    .head       (head)
  );

  // Back end: cursor, escape parser and screen memory.
  tcw_back #(
    .COLUMNS      (COLUMNS),
    .ROWS         (ROWS),
    .TAB_STOP     (TAB_STOP),
    .ESCAPE_DEPTH (ESCAPE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .default_attr (default_attr_r),
    .alert_attr   (alert_attr_r),
    .avail        (avail),
    .item         (head),
    .take         (take),
    .init_busy    (init_busy),
    .res_full     (res_full),
    .res_put      (res_put),
    .res          (res)
  );

  // Result queue decouples the back end from a stalled consumer.
  tcw_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .put   (res_put),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_out)
  );

  assign out_read_char  = res_out.read_char;
  assign out_read_attr  = res_out.read_attr;
  assign out_shown_row  = res_out.shown_row;
  assign out_shown_col  = res_out.shown_col;
  assign out_shown_attr = res_out.shown_attr;

endmodule

// ----- tb/sv/tcw_checker.sv -----
module tcw_checker
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic               in_action,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [INDEX_W-1:0] in_cell_index,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic [CHAR_W-1:0]  out_read_char,
  input  logic [ATTR_W-1:0]  out_read_attr,
  input  logic [ROW_W-1:0]   out_shown_row,
  input  logic [COL_W-1:0]   out_shown_col,
  input  logic [ATTR_W-1:0]  out_shown_attr,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [ATTR_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam int COLS  = 80;
  localparam int LINES = 25;
  localparam int TABW  = 8;
  localparam int EDEP  = 16;
  localparam int CELLS = COLS * LINES;

  logic [15:0]       screen [CELLS];
  int                crow;
  int                ccol;
  logic [ATTR_W-1:0] cattr;
  logic [ATTR_W-1:0] dflt_attr;
  logic [ATTR_W-1:0] alert_attr;
  esc_phase_t        phase;
  int                elen;
  logic [CHAR_W-1:0] ebuf [EDEP];
  result_t           screen_results [$];

  task automatic clear_all();
    for (int i = 0; i < CELLS; i++) screen[i] = {dflt_attr, CH_SPACE};
    crow  = 0;
    ccol  = 0;
    cattr = dflt_attr;
    phase = ESC_IDLE;
    elen  = 0;
  endtask

  task automatic line_feed();
    ccol = 0;
    crow++;
    if (crow >= LINES) begin
      for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = {cattr, CH_SPACE};
      crow = LINES - 1;
      ccol = 0;
    end
  endtask

  task automatic draw(input logic [CHAR_W-1:0] ch);
    if (ccol >= COLS) line_feed();
    screen[crow * COLS + ccol] = {cattr, ch};
    ccol++;
    if (ccol >= COLS) line_feed();
  endtask

  task automatic erase_back();
    if (ccol == 0) begin
      if (crow == 0) return;
      crow--;
      ccol = COLS - 1;
    end else begin
      ccol--;
    end
    screen[crow * COLS + ccol] = {cattr, CH_SPACE};
  endtask

  // Only stored bytes are scanned; "31" needs both digits stored.
  task automatic run_final(input logic [CHAR_W-1:0] fin);
    if (fin == CH_J) begin
      clear_all();
    end else if (fin == CH_H) begin
      crow = 0;
      ccol = 0;
    end else if (fin == CH_M) begin
      for (int i = 0; i < elen; i++) begin
        if (ebuf[i] == CH_ZERO) cattr = dflt_attr;
        if (ebuf[i] == CH_THREE && i + 1 < elen && ebuf[i + 1] == CH_ONE) cattr = alert_attr;
      end
    end
  endtask

  task automatic put_byte(input logic [CHAR_W-1:0] ch);
    if (phase == ESC_SEEN) begin
      phase = (ch == CH_LBRACK) ? ESC_SEQ : ESC_IDLE;
    end else if (phase == ESC_SEQ) begin
      if (elen < EDEP - 1) begin
        ebuf[elen] = ch;
        elen++;
      end
      if (ch >= CH_AT && ch <= CH_TILDE) begin
        run_final(ch);
        phase = ESC_IDLE;
        elen  = 0;
      end
    end else if (ch == CH_ESC) begin
      phase = ESC_SEEN;
      elen  = 0;
    end else if (ch == CH_CR) begin
      ccol = 0;
    end else if (ch == CH_LF) begin
      line_feed();
    end else if (ch == CH_TAB) begin
      do draw(CH_SPACE); while ((ccol % TABW) != 0);
    end else if (ch == CH_BS || ch == CH_DEL) begin
      erase_back();
    end else if (ch >= CH_SPACE) begin
      draw(ch);
    end
  endtask

  // All channels are sampled at the falling edge, where every signal is
  // settled; a handshake seen here completes at the next rising edge.
  always @(negedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      dflt_attr  = DEFAULT_ATTR_RST;
      alert_attr = ALERT_ATTR_RST;
      for (int i = 0; i < EDEP; i++) ebuf[i] = '0;
      clear_all();
      screen_results.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DEFAULT_ATTR) dflt_attr = cfg_data;
        else if (cfg_index == REG_ALERT_ATTR) alert_attr = cfg_data;
      end
      if (out_pop && !out_empty) begin
        got = '{out_read_char, out_read_attr, out_shown_row, out_shown_col, out_shown_attr};
        checked++;
        if (screen_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %p", got);
        end else begin
          want = screen_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (in_push && !in_full) begin
        want = '0;
        if (!in_action) begin
          put_byte(in_char_code);
        end else if (in_cell_index < CELLS) begin
          want.read_char = screen[in_cell_index][7:0];
          want.read_attr = screen[in_cell_index][15:8];
        end
        want.shown_row  = crow[ROW_W-1:0];
        want.shown_col  = ccol[COL_W-1:0];
        want.shown_attr = cattr;
        screen_results.push_back(want);
      end
    end
    pending = screen_results.size();
  end

endmodule

// ----- tb/sv/tb_text_console_writer.sv -----
module tb_text_console_writer;
  import tcw_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic               in_action;
  logic [CHAR_W-1:0]  in_char_code;
  logic [INDEX_W-1:0] in_cell_index;
  logic               out_empty;
  logic               out_pop;
  logic [CHAR_W-1:0]  out_read_char;
  logic [ATTR_W-1:0]  out_read_attr;
  logic [ROW_W-1:0]   out_shown_row;
  logic [COL_W-1:0]   out_shown_col;
  logic [ATTR_W-1:0]  out_shown_attr;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IW-1:0]  cfg_index;
  logic [ATTR_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int checked;
  int words_sent;
  // When set, both sides run back to back without idle cycles.
  bit calm;

  text_console_writer i_dut (.*);

  tcw_checker i_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop. The slowest legal run is well below a third of this.
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: every word is preceded by a random stall unless the phase
  // is calm. Pop is only lowered when a stall actually follows, so it is
  // never dropped and raised in the same step.
  initial begin
    int  gap;
    bit  took;
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      took = 1'b0;
      while (!took) begin
        @(negedge clk);
        took = !out_empty;
        @(posedge clk);
      end
    end
  end

  // Sends one word on the input side after a random gap. Full is looked at
  // in the middle of the cycle, where it is stable.
  task automatic send_word(input logic act, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    bit took;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_action     <= act;
    in_char_code  <= ch;
    in_cell_index <= idx;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_full;
      @(posedge clk);
    end
    words_sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_word(1'b0, ch, INDEX_W'($urandom));
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  task automatic read_cell(input int idx);
    send_word(1'b1, CHAR_W'($urandom), idx[INDEX_W-1:0]);
  endtask

  // Lets the block go quiet: every expected word has come back.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes both attribute registers back to back, valid staying high.
  task automatic set_attrs(input logic [ATTR_W-1:0] dflt, input logic [ATTR_W-1:0] alert);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= REG_DEFAULT_ATTR;
    cfg_data  <= dflt;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_index <= REG_ALERT_ATTR;
    cfg_data  <= alert;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // A control sequence with random parameter bytes. Most parameters are the
  // digits the block understands, so 0 and 31 turn up often; long ones run
  // past the parameter store. A clear is kept rare since it sweeps the screen.
  task automatic random_sequence();
    int                n;
    int                pick;
    logic [CHAR_W-1:0] fin;
    put_char(CH_ESC);
    put_char(CH_LBRACK);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1:    put_char(CH_ZERO);
        2, 3:    put_char(CH_THREE);
        4, 5:    put_char(CH_ONE);
        6:       put_char(8'h3B);
        default: put_char(CHAR_W'($urandom_range(8'h20, 8'h3F)));
      endcase
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) fin = CH_J;
    else if (pick < 4) fin = CH_H;
    else if (pick < 14) fin = CH_M;
    else begin
      fin = CHAR_W'($urandom_range(CH_AT, CH_TILDE));
      if (fin == CH_J) fin = CH_TILDE;
    end
    put_char(fin);
  endtask

  // One random chunk of traffic: mostly printable text and cursor movement,
  // with reads, sequences and a share of plain noise.
  task automatic random_chunk();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) put_char(CHAR_W'($urandom_range(8'h20, 8'hFF)));
    else if (pick < 50) begin
      if ($urandom_range(0, 9) == 0) read_cell($urandom_range(2000, 2047));
      else read_cell($urandom_range(0, 1999));
    end
    else if (pick < 55) put_char(CH_LF);
    else if (pick < 58) put_char(CH_CR);
    else if (pick < 62) put_char(CH_TAB);
    else if (pick < 66) put_char(CH_BS);
    else if (pick < 68) put_char(CH_DEL);
    else if (pick < 80) random_sequence();
    else if (pick < 83) begin
      // Escape followed by a random byte: unless it is a bracket, both are swallowed.
      put_char(CH_ESC);
      put_char(CHAR_W'($urandom));
    end
    else put_char(CHAR_W'($urandom));
  endtask

  initial begin
    logic [ATTR_W-1:0] dflt [4];
    logic [ATTR_W-1:0] alert [4];
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_action     = 1'b0;
    in_char_code  = '0;
    in_cell_index = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_DEFAULT_ATTR;
    cfg_data      = '0;
    calm          = 1'b0;
    words_sent    = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset attributes: a letter and the byte 0xFF, reads of
    // the first, last and an out-of-range cell, each control byte, both
    // attribute parameters, an escape without a bracket, home and clear,
    // and a backspace at the home position.
    put_char(8'h41);
    put_char(8'hFF);
    read_cell(0);
    read_cell(1999);
    read_cell(2047);
    put_char(CH_CR);
    put_char(CH_LF);
    put_char(CH_TAB);
    put_char(CH_BS);
    put_char(CH_DEL);
    put_char(8'h01);
    put_text("\033[31mx\033[0m\033Q\033[H");
    put_char(CH_BS);
    put_text("\033[J");
    drain();

    dflt[0] = 8'h00; alert[0] = 8'hFF;
    dflt[1] = 8'hFF; alert[1] = 8'h00;
    dflt[2] = ATTR_W'($urandom); alert[2] = ATTR_W'($urandom);
    dflt[3] = DEFAULT_ATTR_RST; alert[3] = ALERT_ATTR_RST;
    for (int p = 0; p < 4; p++) begin
      set_attrs(dflt[p], alert[p]);
      calm = (p == 1);
      // Start each phase but the last from a clean screen so the new default shows up.
      if (p != 3) put_text("\033[J");
      while (words_sent < 30 + 450 * (p + 1)) random_chunk();
      drain();
    end

    repeat (2100) @(posedge clk);
    $display("Sent %0d words over four attribute settings; %0d result words checked.",
             words_sent, checked);
    $display("Covered text, wrap and scroll, tabs, erase, reads and escape sequences.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tcw_pkg.sv
design/tcw_front.sv
design/tcw_outq.sv
design/tcw_back.sv
design/text_console_writer.sv
tb/sv/tcw_checker.sv
tb/sv/tb_text_console_writer.sv
